// File: sv/tfsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfsr_pkg: shared types and codes for the tagged queue
// Field widths, request kinds, status codes and the result bundle.
// ----------------------------------------------------------------------------
package tfsr_pkg;

	localparam int KIND_W   = 3;
	localparam int HANDLE_W = 32;
	localparam int TAG_W    = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	localparam logic [KIND_W-1:0] KIND_PUSH     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_POP      = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PEEK     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CONTAINS = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] out_handle;
		logic [TAG_W-1:0]    out_tag;
		logic [OCC_W-1:0]    occupancy;
	} result_t;

endpackage

// File: sv/tfsr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfsr_mem: entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tfsr_mem import tfsr_pkg::*; #(
	parameter int DEPTH  = 16,
	parameter int KEY_W  = 32,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [KEY_W-1:0]  whandle,
	input  logic [TAG_W-1:0]  wtag,
	input  logic [ADDR_W-1:0] raddr,
	output logic [KEY_W-1:0]  rhandle,
	output logic [TAG_W-1:0]  rtag
);

	logic [KEY_W-1:0] handle_mem [DEPTH];
	logic [TAG_W-1:0] tag_mem [DEPTH];
	logic [KEY_W-1:0] rhandle_q;
	logic [TAG_W-1:0] rtag_q;

	always_ff @(posedge clk) begin
		if (we) begin
			handle_mem[waddr] <= whandle;
			tag_mem[waddr]    <= wtag;
		end
		rhandle_q <= handle_mem[raddr];
		rtag_q    <= tag_mem[raddr];
	end

	assign rhandle = rhandle_q;
	assign rtag    = rtag_q;

endmodule

// File: sv/tfsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfsr_ctrl: request sequencer
// Circular queue pointers, key scan with one shared comparator, and the
// shift-down pass that closes the gap after a remove.
// ----------------------------------------------------------------------------
module tfsr_ctrl import tfsr_pkg::*; #(
	parameter int DEPTH       = 16,
	parameter int HANDLE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_take,
	input  logic [KIND_W-1:0]   kind,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [TAG_W-1:0]    tag,
	output logic                idle,
	output logic                done,
	input  logic                done_take,
	output result_t             result
);

	localparam int KEY_W  = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HEAD  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]          state_q;
	logic [KIND_W-1:0]   kind_q;
	logic [KEY_W-1:0]    key_q;
	logic [PTR_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    idx_q;
	logic [STATUS_W-1:0] status_q;
	logic [HANDLE_W-1:0] oh_q;
	logic [TAG_W-1:0]    ot_q;

	logic [KEY_W-1:0]    key_in;
	logic [CNT_W-1:0]    count_m1;
	logic [CNT_W-1:0]    idx_p1;
	logic [CNT_W-1:0]    idx_p2;
	logic                is_empty;
	logic                is_full;
	logic                hit;
	logic [CNT_W-1:0]    roff;
	logic [CNT_W-1:0]    woff;
	logic [SUM_W-1:0]    head_ext;
	logic [SUM_W-1:0]    rsum;
	logic [SUM_W-1:0]    wsum;
	logic [SUM_W-1:0]    rsum_w;
	logic [SUM_W-1:0]    wsum_w;
	logic [PTR_W-1:0]    raddr;
	logic [PTR_W-1:0]    waddr;
	logic [PTR_W-1:0]    head_next;
	logic                we;
	logic [KEY_W-1:0]    whandle;
	logic [TAG_W-1:0]    wtag;
	logic [KEY_W-1:0]    rhandle;
	logic [TAG_W-1:0]    rtag;
	logic [HANDLE_W-1:0] rhandle_ext;
	logic [CNT_W+OCC_W-1:0] count_ext;

	assign key_in   = handle[KEY_W-1:0];
	assign count_m1 = count_q - CNT_W'(1);
	assign idx_p1   = idx_q + CNT_W'(1);
	assign idx_p2   = idx_q + CNT_W'(2);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign hit      = (rhandle == key_q);

	always_comb begin
		head_ext = '0;
		head_ext[PTR_W-1:0] = head_q;
		rhandle_ext = '0;
		rhandle_ext[KEY_W-1:0] = rhandle;
		count_ext = '0;
		count_ext[CNT_W-1:0] = count_q;
	end

	always_comb begin
		unique case (state_q)
			S_SCAN:  roff = idx_p1;
			S_SHIFT: roff = idx_p2;
			default: roff = '0;
		endcase
		woff = (state_q == S_SHIFT) ? idx_q : count_q;
		rsum = head_ext + {1'b0, roff};
		wsum = head_ext + {1'b0, woff};
		rsum_w = (rsum >= SUM_W'(DEPTH)) ? rsum - SUM_W'(DEPTH) : rsum;
		wsum_w = (wsum >= SUM_W'(DEPTH)) ? wsum - SUM_W'(DEPTH) : wsum;
		raddr = rsum_w[PTR_W-1:0];
		waddr = wsum_w[PTR_W-1:0];
		head_next = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	end

	always_comb begin
		we      = 1'b0;
		whandle = key_in;
		wtag    = tag;
		if (state_q == S_SHIFT) begin
			we      = 1'b1;
			whandle = rhandle;
			wtag    = rtag;
		end else if (state_q == S_IDLE && req_take && kind == KIND_PUSH && !is_full) begin
			we = 1'b1;
		end
	end

	tfsr_mem #(
		.DEPTH  (DEPTH),
		.KEY_W  (KEY_W),
		.ADDR_W (PTR_W)
	) u_mem (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.whandle (whandle),
		.wtag    (wtag),
		.raddr   (raddr),
		.rhandle (rhandle),
		.rtag    (rtag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						kind_q   <= kind;
						key_q    <= key_in;
						idx_q    <= '0;
						status_q <= ST_EMPTY;
						oh_q     <= '0;
						ot_q     <= '0;
						state_q  <= S_FIN;
						unique case (kind)
							KIND_PUSH: begin
								if (is_full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
									count_q  <= count_q + CNT_W'(1);
								end
							end
							KIND_POP, KIND_PEEK: begin
								if (!is_empty) state_q <= S_HEAD;
							end
							KIND_CONTAINS, KIND_REMOVE: begin
								if (!is_empty) state_q <= S_SCAN;
							end
							default: ;
						endcase
					end
				end
				S_HEAD: begin
					status_q <= ST_OK;
					oh_q     <= rhandle_ext;
					ot_q     <= rtag;
					if (kind_q == KIND_POP) begin
						head_q  <= head_next;
						count_q <= count_m1;
					end
					state_q <= S_FIN;
				end
				S_SCAN: begin
					if (hit) begin
						status_q <= ST_OK;
						if (kind_q == KIND_REMOVE) begin
							if (idx_q == count_m1) begin
								count_q <= count_m1;
								state_q <= S_FIN;
							end else begin
								state_q <= S_SHIFT;
							end
						end else begin
							state_q <= S_FIN;
						end
					end else if (idx_q == count_m1) begin
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_p1;
					end
				end
				S_SHIFT: begin
					if (idx_p1 == count_m1) begin
						count_q <= count_m1;
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_p1;
					end
				end
				S_FIN: begin
					if (done_take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_FIN);

	always_comb begin
		result.status     = status_q;
		result.out_handle = oh_q;
		result.out_tag    = ot_q;
		result.occupancy  = count_ext[OCC_W-1:0];
	end

endmodule

// File: sv/tagged_fifo_with_search_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_fifo_with_search_remove: ordered handle/tag queue with key removal
// Push, pop, peek, contains and remove-oldest-match over a circular store.
//
// Channel   Handshake             Payload
// request   req_valid/req_stall   kind, handle, tag
// response  rsp_valid/rsp_stall   status, out_handle, out_tag, occupancy
//
// Push and unknown kinds go straight to the finish state; pop and peek first read
// the head entry unless the queue is empty. Contains scans from the oldest entry:
// the single key comparator looks at one stored entry per cycle through the
// registered memory read port. Remove then shifts each entry behind the match down.
// Reset empties the queue; stored entries are not cleared.
// A stalled response is held in the output register while the next request
// is taken; the sequencer waits only when it finishes behind a held response.
// ----------------------------------------------------------------------------
module tagged_fifo_with_search_remove import tfsr_pkg::*; #(
	parameter int DEPTH       = 16,
	parameter int HANDLE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [KIND_W-1:0]   kind,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [TAG_W-1:0]    tag,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [STATUS_W-1:0] status,
	output logic [HANDLE_W-1:0] out_handle,
	output logic [TAG_W-1:0]    out_tag,
	output logic [OCC_W-1:0]    occupancy
);

	logic    idle;
	logic    done;
	logic    slot_free;
	logic    req_take;
	result_t result;
	logic    rsp_valid_q;
	result_t rsp_q;

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = !idle;
	assign req_take  = req_valid && idle;

	tfsr_ctrl #(
		.DEPTH       (DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_take  (req_take),
		.kind      (kind),
		.handle    (handle),
		.tag       (tag),
		.idle      (idle),
		.done      (done),
		.done_take (slot_free),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (slot_free) begin
			rsp_valid_q <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && done) rsp_q <= result;
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = rsp_q.status;
	assign out_handle = rsp_q.out_handle;
	assign out_tag    = rsp_q.out_tag;
	assign occupancy  = rsp_q.occupancy;

endmodule
